[design/lcg_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared constants, types and functions of the life cell generation stream.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int MAX_COLS_DEF = 512;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam int ROWS_RESET = 100;
    localparam int COLS_RESET = 300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE = 2'd0,
        REG_COLS_IN_USE = 2'd1
    } t_reg_idx;

    // Classification of one accepted item, worked out in the front part.
    typedef struct packed {
        logic top_ok;   // the row two above lies on the board
        logic mid_ok;   // the row one above lies on the board
        logic bot;      // the incoming cell, already forced dead off the board
        logic col0;     // first column of a row
        logic emit;     // this item reports a cell
        logic last;     // final item of the frame
    } t_cls;

    // A register value of zero counts as one, and values beyond the limit
    // are held at the limit.
    function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // B3/S23: bit 4 of the window is the centre cell.
    function automatic logic next_state(logic [8:0] win);
        logic [3:0] n;
        n = 4'($countones({win[8:5], win[3:0]}));
        if (win[4]) begin
            return (n == 4'd2) || (n == 4'd3);
        end
        return n == 4'd3;
    endfunction

endpackage

[design/lcg_front.sv]
// ----------------------------------------------------------------------------
// lcg_front
// Accepts board and drain items, tracks the raster position and classifies
// each item for the back part.
// ----------------------------------------------------------------------------
module lcg_front #(
    parameter int MAX_COLS = lcg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lcg_pkg::MAX_ROWS_DEF,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int CCNT_W = $clog2(MAX_COLS + 1),
    localparam int RCNT_W = $clog2(MAX_ROWS + 2)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [RCNT_W-1:0]   i_rows,
    input  logic [CCNT_W-1:0]   i_cols,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic                i_cell_alive,
    output logic                o_push,
    input  logic                i_push_ready,
    output logic [COL_W-1:0]    o_addr,
    output lcg_pkg::t_cls       o_cls
);

    logic [RCNT_W-1:0] r_ir, n_ir;
    logic [CCNT_W-1:0] r_ic, n_ic;
    logic              v_live;
    logic              col_wrap;

    assign o_in_ready = i_push_ready;
    assign o_push     = i_in_valid && i_push_ready;
    assign o_addr     = r_ic[COL_W-1:0];

    assign v_live   = i_cell_alive & ~i_operation;
    assign col_wrap = (r_ic + CCNT_W'(1)) == i_cols;

    always_comb begin
        o_cls.top_ok = r_ir >= RCNT_W'(2);
        o_cls.mid_ok = (r_ir >= RCNT_W'(1)) && (r_ir <= i_rows);
        o_cls.bot    = v_live && (r_ir < i_rows);
        o_cls.col0   = r_ic == '0;
        o_cls.emit   = (r_ic == '0) ? (r_ir >= RCNT_W'(2)) : (r_ir >= RCNT_W'(1));
        o_cls.last   = r_ir > i_rows;
    end

    always_comb begin
        n_ir = r_ir;
        n_ic = r_ic;
        if (i_restart) begin
            n_ir = '0;
            n_ic = '0;
        end else if (o_push) begin
            if (o_cls.last) begin
                n_ir = '0;
                n_ic = '0;
            end else if (col_wrap) begin
                n_ic = '0;
                n_ir = r_ir + RCNT_W'(1);
            end else begin
                n_ic = r_ic + CCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir <= '0;
            r_ic <= '0;
        end else begin
            r_ir <= n_ir;
            r_ic <= n_ic;
        end
    end

endmodule

[design/lcg_queue.sv]
// ----------------------------------------------------------------------------
// lcg_queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module lcg_queue #(
    parameter int W = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  logic [W-1:0]  i_data,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output logic [W-1:0]  o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count, n_count;
    logic         do_push, do_pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_data       = r_mem[r_rd_ptr];

    assign do_push = i_push && o_push_ready;
    assign do_pop  = i_pop && o_pop_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/lcg_back.sv]
// ----------------------------------------------------------------------------
// lcg_back
// Line buffer, 3x3 window and rule evaluation, with the output register.
// ----------------------------------------------------------------------------
module lcg_back #(
    parameter int MAX_COLS = lcg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lcg_pkg::MAX_ROWS_DEF,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int ROW_W  = $clog2(MAX_ROWS),
    localparam int CCNT_W = $clog2(MAX_COLS + 1),
    localparam int RCNT_W = $clog2(MAX_ROWS + 2)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [RCNT_W-1:0]   i_rows,
    input  logic [CCNT_W-1:0]   i_cols,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  logic [COL_W-1:0]    i_q_addr,
    input  lcg_pkg::t_cls       i_q_cls,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_next_alive,
    output logic [ROW_W-1:0]    o_cell_row,
    output logic [COL_W-1:0]    o_cell_col,
    output logic                o_last_of_frame
);

    // Each line buffer entry holds {older row, newer row} for one column.
    logic [1:0]        r_line [MAX_COLS];

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_addr;
    lcg_pkg::t_cls     r_s1_cls;
    logic [1:0]        r_rd, r_byp_data;
    logic              r_byp;

    logic [8:0]        r_window, n_window;
    logic [RCNT_W-1:0] r_orow, n_orow;
    logic [CCNT_W-1:0] r_ocol, n_ocol;

    logic              r_out_valid;
    logic              r_next_alive;
    logic [ROW_W-1:0]  r_cell_row;
    logic [COL_W-1:0]  r_cell_col;
    logic              r_last;

    logic              advance, commit, emit_now;
    logic [1:0]        rd_data, wr_data;
    logic [2:0]        new_col;
    logic [8:0]        win;
    logic              last_cell;

    assign advance  = !r_s1_valid || !r_s1_cls.emit || !r_out_valid || i_out_ready;
    assign commit   = advance && r_s1_valid;
    assign emit_now = commit && r_s1_cls.emit;
    assign o_q_pop  = advance && i_q_valid;

    assign rd_data = r_byp ? r_byp_data : r_rd;
    assign wr_data = {rd_data[0], r_s1_cls.bot};
    assign new_col = {r_s1_cls.bot, rd_data[0] & r_s1_cls.mid_ok,
                      rd_data[1] & r_s1_cls.top_ok};

    always_comb begin
        if (r_s1_cls.col0) begin
            win      = {3'b000, r_window[8:3]};
            n_window = {new_col, 6'b000000};
        end else begin
            n_window = {new_col, r_window[8:3]};
            win      = n_window;
        end
    end

    assign last_cell = ((r_orow + RCNT_W'(1)) == i_rows) && ((r_ocol + CCNT_W'(1)) == i_cols);

    always_comb begin
        n_orow = r_orow;
        n_ocol = r_ocol;
        if (emit_now) begin
            if ((r_ocol + CCNT_W'(1)) == i_cols) begin
                n_ocol = '0;
                n_orow = r_orow + RCNT_W'(1);
            end else begin
                n_ocol = r_ocol + CCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_line[r_s1_addr] <= wr_data;
        end
        if (o_q_pop) begin
            r_rd <= r_line[i_q_addr];
        end
    end

    // The older item writes the entry that the newer one reads at the same edge.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_addr  <= i_q_addr;
            r_s1_cls   <= i_q_cls;
            r_byp      <= commit && (r_s1_addr == i_q_addr);
            r_byp_data <= wr_data;
        end
        if (emit_now) begin
            r_next_alive <= lcg_pkg::next_state(win);
            r_cell_row   <= r_orow[ROW_W-1:0];
            r_cell_col   <= r_ocol[COL_W-1:0];
            r_last       <= last_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
        end else begin
            if (advance) begin
                r_s1_valid <= i_q_valid;
            end
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_restart || (commit && r_s1_cls.last)) begin
                r_window <= '0;
                r_orow   <= '0;
                r_ocol   <= '0;
            end else begin
                if (commit) begin
                    r_window <= n_window;
                end
                r_orow <= n_orow;
                r_ocol <= n_ocol;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_alive    = r_next_alive;
    assign o_cell_row      = r_cell_row;
    assign o_cell_col      = r_cell_col;
    assign o_last_of_frame = r_last;

endmodule

[design/life_cell_generation_stream.sv]
// ----------------------------------------------------------------------------
// life_cell_generation_stream
// One generation of the B3/S23 cellular automaton over a raster-order stream.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   i_operation, i_cell_alive
//  out      source     o_out_valid / i_out_ready o_next_alive, o_cell_row,
//                                                o_cell_col, o_last_of_frame
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item a cycle is sustained while the output is not stalled. A result is
// formed from the registered line buffer read and leaves an output register.
// Synchronous active-low reset empties the pipeline and restarts the frame.
// A stalled output holds the back part; the two-entry queue then fills and
// drops o_in_ready. The line buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module life_cell_generation_stream #(
    parameter int MAX_COLS = lcg_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lcg_pkg::MAX_ROWS_DEF,
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int ROW_W  = $clog2(MAX_ROWS),
    localparam int CCNT_W = $clog2(MAX_COLS + 1),
    localparam int RCNT_W = $clog2(MAX_ROWS + 2)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic                           i_cell_alive,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_next_alive,
    output logic [ROW_W-1:0]               o_cell_row,
    output logic [COL_W-1:0]               o_cell_col,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = COL_W + $bits(lcg_pkg::t_cls);

    logic [RCNT_W-1:0] r_rows;
    logic [CCNT_W-1:0] r_cols;
    logic              cfg_wr, restart;

    logic              push, push_ready, q_valid, q_pop;
    logic [COL_W-1:0]  f_addr, q_addr;
    lcg_pkg::t_cls     f_cls, q_cls;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        unique case (i_cfg_index)
            lcg_pkg::REG_ROWS_IN_USE,
            lcg_pkg::REG_COLS_IN_USE: restart = cfg_wr;
            default:                  restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RCNT_W'(lcg_pkg::clamp_dim(32'(lcg_pkg::ROWS_RESET), 32'(MAX_ROWS)));
            r_cols <= CCNT_W'(lcg_pkg::clamp_dim(32'(lcg_pkg::COLS_RESET), 32'(MAX_COLS)));
        end else if (cfg_wr) begin
            if (i_cfg_index == lcg_pkg::REG_ROWS_IN_USE) begin
                r_rows <= RCNT_W'(lcg_pkg::clamp_dim(32'(i_cfg_data), 32'(MAX_ROWS)));
            end else if (i_cfg_index == lcg_pkg::REG_COLS_IN_USE) begin
                r_cols <= CCNT_W'(lcg_pkg::clamp_dim(32'(i_cfg_data[9:0]), 32'(MAX_COLS)));
            end
        end
    end

    lcg_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_rows       (r_rows),
        .i_cols       (r_cols),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_cell_alive (i_cell_alive),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_addr       (f_addr),
        .o_cls        (f_cls)
    );

    lcg_queue #(
        .W (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       ({f_addr, f_cls}),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_data       ({q_addr, q_cls})
    );

    lcg_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (restart),
        .i_rows          (r_rows),
        .i_cols          (r_cols),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_addr        (q_addr),
        .i_q_cls         (q_cls),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_alive    (o_next_alive),
        .o_cell_row      (o_cell_row),
        .o_cell_col      (o_cell_col),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

[dv/life_cell_generation_stream_tb.sv]
// ----------------------------------------------------------------------------
// life_cell_generation_stream_tb
// Self-checking bench for the B3/S23 generation stream. Boards stream in one
// item per cell in raster order, followed by the drain items that flush the
// last row. A predictor kept alongside the block works out every reported
// cell as each item is accepted. Each result that leaves the block is checked
// field by field against the oldest prediction. Board sizes, operation
// mismatches, register clamping, ignored register indexes, a mid-frame
// restart, random idling on both sides and a long output stall are covered.
// ----------------------------------------------------------------------------
module life_cell_generation_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_W    = lcg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = lcg_pkg::CFG_DATA_W;
    localparam int ROWS_RESET   = lcg_pkg::ROWS_RESET;
    localparam int COLS_RESET   = lcg_pkg::COLS_RESET;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int BOARD_ROWS   = lcg_pkg::MAX_ROWS_DEF;
    localparam int BOARD_COLS   = lcg_pkg::MAX_COLS_DEF;
    localparam int ROW_W        = $clog2(BOARD_ROWS);
    localparam int COL_W        = $clog2(BOARD_COLS);
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int RESET_SPAN   = 24;
    localparam int LIMIT_SPAN   = 30;
    localparam int RANDOM_ITEMS = 270;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_UNLISTED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNLISTED_HI = 2'd3;

    // Row-major 3x4 board with a dense middle, so that births, survivals and
    // deaths by crowding all occur in one frame.
    localparam logic [11:0] SMALL_PATTERN = 12'b1110_0111_1011;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic             alive;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_cell_result;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  i_operation  = 1'b0;
    logic                  i_cell_alive = 1'b0;
    logic                  i_out_ready  = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_next_alive;
    logic [ROW_W-1:0]      o_cell_row;
    logic [COL_W-1:0]      o_cell_col;
    logic                  o_last_of_frame;
    logic                  o_cfg_ready;

    t_idle_mode  idle_mode     = IDLE_NONE;
    logic        long_hold_req = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned items_sent    = 0;

    // Predictor state.
    logic [10:0]  rows_setting;
    logic [9:0]   cols_setting;
    bit           upper_line [BOARD_COLS];
    bit           lower_line [BOARD_COLS];
    logic [8:0]   window;
    int unsigned  in_row, in_col, out_row, out_col;
    t_cell_result expected_cells [$];

    life_cell_generation_stream dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_cell_alive   (i_cell_alive),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_alive   (o_next_alive),
        .o_cell_row     (o_cell_row),
        .o_cell_col     (o_cell_col),
        .o_last_of_frame(o_last_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("life_cell_generation_stream_tb failed");
            $finish;
        end
    end

    function automatic int unsigned idle_percent(t_idle_mode mode, bit for_sender);
        if (mode == IDLE_BOTH) begin
            return 9;
        end
        if (mode == (for_sender ? IDLE_SENDER : IDLE_RECEIVER)) begin
            return 51;
        end
        return 0;
    endfunction

    // A long hold, once requested, runs out on its own count.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (long_hold_req) begin
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= idle_percent(idle_mode, 1'b0);
        end
    end

    function automatic int unsigned clamp_size(int unsigned setting, int unsigned limit);
        if (setting == 0) begin
            return 1;
        end
        return (setting > limit) ? limit : setting;
    endfunction

    function automatic void restart_generation();
        window   = '0;
        in_row   = 0;
        in_col   = 0;
        out_row  = 0;
        out_col  = 0;
    endfunction

    function automatic void predict_item(input logic op, input logic alive);
        int unsigned  nrows, ncols, row, col, live, b;
        logic         top, mid, bot;
        logic [2:0]   column;
        logic [8:0]   win;
        bit           emit;
        t_cell_result next_cell;
        nrows = clamp_size(rows_setting, BOARD_ROWS);
        ncols = clamp_size(cols_setting, BOARD_COLS);
        row   = in_row;
        col   = (in_col >= ncols) ? ncols - 1 : in_col;
        // Rows above the board and rows below it count as dead.
        top = (row >= 2 && row - 2 < nrows) ? upper_line[col] : 1'b0;
        mid = (row >= 1 && row - 1 < nrows) ? lower_line[col] : 1'b0;
        bot = (row < nrows) ? (alive & ~op) : 1'b0;
        upper_line[col] = lower_line[col];
        lower_line[col] = bot;
        column = {bot, mid, top};
        // At column zero the window still holds the last column of the row
        // above, whose right-hand neighbours lie off the board.
        if (col == 0) begin
            win    = {3'b000, window[8:3]};
            window = {column, 6'b000000};
            emit   = row >= 2;
        end else begin
            window = {column, window[8:3]};
            win    = window;
            emit   = row >= 1;
        end
        if (emit) begin
            live = 0;
            for (b = 0; b < 9; b++) begin
                if (b != 4) begin
                    live += win[b];
                end
            end
            next_cell.alive = win[4] ? (live == 2 || live == 3) : (live == 3);
            next_cell.row   = ROW_W'(out_row);
            next_cell.col   = COL_W'(out_col);
            next_cell.last  = (out_row + 1 >= nrows) && (out_col + 1 >= ncols);
            expected_cells.push_back(next_cell);
            out_col++;
            if (out_col >= ncols) begin
                out_col = 0;
                out_row++;
            end
        end
        if (row >= nrows + 1) begin
            restart_generation();
        end else begin
            col++;
            if (col >= ncols) begin
                col = 0;
                row++;
            end
            in_row = row;
            in_col = col;
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            rows_setting = 11'(ROWS_RESET);
            cols_setting = 10'(COLS_RESET);
            foreach (upper_line[i]) begin
                upper_line[i] = 1'b0;
                lower_line[i] = 1'b0;
            end
            restart_generation();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lcg_pkg::REG_ROWS_IN_USE) begin
                    rows_setting = i_cfg_data;
                    restart_generation();
                end else if (i_cfg_index == lcg_pkg::REG_COLS_IN_USE) begin
                    cols_setting = i_cfg_data[9:0];
                    restart_generation();
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_item(i_operation, i_cell_alive);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected result: row %0d col %0d", o_cell_row, o_cell_col);
                    error_count++;
                end else begin
                    want = expected_cells.pop_front();
                    check_field("next_alive", want.alive, o_next_alive);
                    check_field("cell_row", want.row, o_cell_row);
                    check_field("cell_col", want.col, o_cell_col);
                    check_field("last_of_frame", want.last, o_last_of_frame);
                end
            end
        end
    end

    task automatic send_cell(input logic op, input logic alive);
        while ($urandom_range(0, 99) < idle_percent(idle_mode, 1'b1)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_cell_alive <= alive;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Sends raster positions first .. first+count-1 of a frame. Positions past
    // the board are drain items; a noisy span flips some operations.
    task automatic send_span(input int unsigned rows, input int unsigned cols,
                             input int unsigned first, input int unsigned count,
                             input bit noisy);
        int unsigned density, k;
        logic        op;
        density = $urandom_range(10, 90);
        for (k = first; k < first + count; k++) begin
            op = (k >= rows * cols);
            if (noisy && $urandom_range(0, 4) == 0) begin
                op = ~op;
            end
            send_cell(op, $urandom_range(0, 99) < density);
        end
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // The start of a reset-size frame, where no cell may be reported before a
    // whole row has gone in. It is cut short by the next write.
    task automatic test_reset_sizes();
        send_span(ROWS_RESET, COLS_RESET, 0, RESET_SPAN, 1'b0);
    endtask

    // Zero in both registers gives a one-cell board.
    task automatic test_single_cell_board();
        write_register(lcg_pkg::REG_ROWS_IN_USE, '0);
        write_register(lcg_pkg::REG_COLS_IN_USE, '0);
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b1);
    endtask

    // A board cell sent as a drain counts as dead, and drain positions count
    // as dead whatever their fields carry.
    task automatic test_small_board();
        int unsigned k;
        write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(3));
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(4));
        for (k = 0; k < 17; k++) begin
            if (k < 12) begin
                send_cell(k == 7, SMALL_PATTERN[k] | (k == 7));
            end else begin
                send_cell(k[0], k[1]);
            end
        end
    endtask

    task automatic test_ignored_registers();
        idle_mode <= IDLE_BOTH;
        write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(3));
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(5));
        send_span(3, 5, 0, 10, 1'b0);
        // Unlisted indexes leave the frame running where it was.
        write_register(REG_UNLISTED_LO, '1);
        write_register(REG_UNLISTED_HI, '0);
        send_span(3, 5, 10, 11, 1'b0);
        // A listed write in mid-frame starts the frame again.
        send_span(3, 5, 0, 7, 1'b0);
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(5));
        send_span(3, 5, 0, 21, 1'b0);
    endtask

    // Clamped sizes and the largest board, each checked over the start of a frame.
    task automatic test_size_limits();
        idle_mode <= IDLE_SENDER;
        write_register(lcg_pkg::REG_ROWS_IN_USE, '1);
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(1));
        send_span(BOARD_ROWS, 1, 0, LIMIT_SPAN, 1'b0);
        write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(1));
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(1023));
        send_span(1, BOARD_COLS, 0, LIMIT_SPAN, 1'b0);
        write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(BOARD_ROWS));
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(BOARD_COLS));
        send_span(BOARD_ROWS, BOARD_COLS, 0, LIMIT_SPAN, 1'b0);
    endtask

    task automatic test_output_backpressure();
        idle_mode <= IDLE_NONE;
        write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(4));
        write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(8));
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;
        send_span(4, 8, 0, 41, 1'b0);
        send_span(4, 8, 0, 41, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned start, rows, cols, total, frames, frame_idx, pick, round;
        bit          whole;
        start = items_sent;
        round = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            // Each idling phase comes round in turn.
            idle_mode <= t_idle_mode'(round % 4);
            round++;
            rows = $urandom_range(1, 6);
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            write_register(lcg_pkg::REG_ROWS_IN_USE, CFG_DATA_W'(rows));
            write_register(lcg_pkg::REG_COLS_IN_USE, CFG_DATA_W'(cols));
            total  = rows * cols + cols + 1;
            frames = $urandom_range(1, 3);
            whole  = 1'b1;
            // Mostly whole frames back to back; now and then a noisy one, or
            // one cut short and restarted by the next register write.
            for (frame_idx = 0; frame_idx < frames && whole; frame_idx++) begin
                pick = $urandom_range(0, 9);
                if (pick == 9) begin
                    send_span(rows, cols, 0, $urandom_range(1, total - 1), 1'b0);
                    whole = 1'b0;
                end else begin
                    send_span(rows, cols, 0, total, pick == 8);
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_sizes();
        test_single_cell_board();
        test_small_board();
        test_ignored_registers();
        test_size_limits();
        test_output_backpressure();
        test_random_frames();
        wait_until_drained();
        if (expected_cells.size() != 0) begin
            $error("%0d expected cells never arrived", expected_cells.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("life_cell_generation_stream_tb passed");
        end else begin
            $display("life_cell_generation_stream_tb failed");
        end
        $finish;
    end

endmodule
